[src/msr_pkg.sv]
package msr_pkg;

   localparam int WORD_BITS = 32;
   localparam int CNT_BITS = 6;
   localparam int NR_LAST = 257;

   typedef enum logic [2:0] {
      MUL_IDLE,
      MUL_RUN,
      MUL_REDUCE,
      MUL_DONE
   } mul_state_type;

   typedef struct packed {
      logic                 start;
      logic [WORD_BITS-1:0] x;
      logic [WORD_BITS-1:0] y;
      logic [WORD_BITS-1:0] m;
   } mul_req_type;

   typedef struct packed {
      logic                 done;
      logic [WORD_BITS-1:0] prod;
   } mul_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RED,
      ST_EULER,
      ST_EULER_CHK,
      ST_FACTOR,
      ST_SHORT,
      ST_NR,
      ST_NR_CHK,
      ST_POW_C,
      ST_POW_T,
      ST_POW_R,
      ST_LOOP,
      ST_SQ,
      ST_SQ_CHK,
      ST_B,
      ST_B_CHK,
      ST_C,
      ST_T,
      ST_R,
      ST_OUT
   } ctl_state_type;

   typedef enum logic [1:0] {
      PW_IDLE,
      PW_MUL_ACC,
      PW_MUL_SQ,
      PW_DONE
   } pow_state_type;

endpackage

[src/msr_mulmod.sv]
module msr_mulmod
   import msr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   mul_state_type state_ff, state_in;
   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] y_ff, y_in;
   logic [WORD_BITS-1:0] m_ff, m_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS:0]   dbl;
   logic [WORD_BITS+1:0] sum;
   logic [WORD_BITS+1:0] sub1;
   logic [WORD_BITS+1:0] red;

   // acc = (2*acc + bit*y) mod m, acc < m kept, one bit of x per cycle
   always_comb begin
      dbl  = {acc_ff, 1'b0};
      sum  = {1'b0, dbl} + (x_ff[WORD_BITS-1] ? {2'b00, y_ff} : '0);
      sub1 = (sum >= {2'b00, m_ff}) ? sum - {2'b00, m_ff} : sum;
      red  = (sub1 >= {2'b00, m_ff}) ? sub1 - {2'b00, m_ff} : sub1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MUL_IDLE:   if (req.start) state_in = MUL_REDUCE;
         MUL_REDUCE: state_in = MUL_RUN;
         MUL_RUN:    if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) state_in = MUL_DONE;
         MUL_DONE:   state_in = MUL_IDLE;
         default:    state_in = MUL_IDLE;
      endcase
   end

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      m_in   = m_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         MUL_IDLE: begin
            x_in   = req.x;
            y_in   = req.y;
            m_in   = req.m;
            acc_in = '0;
            cnt_in = '0;
         end
         MUL_REDUCE: begin
            // operands below m by caller contract except y; reduce y once by m
            if (y_ff >= m_ff) y_in = y_ff - m_ff;
         end
         MUL_RUN: begin
            acc_in = red[WORD_BITS-1:0];
            x_in   = {x_ff[WORD_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= MUL_IDLE;
      else       state_ff <= state_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = (state_ff == MUL_DONE);
   assign rsp.prod = acc_ff;

`ifndef SYNTH
   a_done_short: assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> !rsp.done) else $error("done held");
   a_acc_lt_m: assert property (@(posedge clock) disable iff (reset)
      rsp.done |-> (acc_ff < m_ff)) else $error("product not reduced");
   a_run_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MUL_RUN) |-> (cnt_ff < CNT_BITS'(WORD_BITS)))
      else $error("count overrun");
`endif

endmodule

[src/modular_square_root_unit.sv]
// channel | ports                            | fields (low bit up)
// req     | req_tvalid req_tready req_tdata  | value[31:0] modulus[63:32]
// rsp     | rsp_tvalid rsp_tready rsp_tdata  | root[31:0] no_root[32]
// One item at a time; req_tready high only in idle, so the next word waits for the result.
// Zero value, modulus two or an invalid modulus: the check state goes straight to the result.
// Else restoring division reduces the value, then exponentiations use two multiplies per
// exponent bit: Euler's test first, then one more power for a modulus 3 mod 4 and more
// for a prime 1 mod 4; a composite modulus can run the non-residue search to its last candidate.
// Reset returns the controller to idle; the result holds until taken.
module modular_square_root_unit
   import msr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // value[31:0], modulus[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // root[31:0], no_root[32], zero fill
);

   localparam int W = WORD_BITS;

   ctl_state_type state_ff, state_in;
   pow_state_type pw_ff, pw_in;
   logic [W-1:0] a_ff, a_in, p_ff, p_in;
   logic [W-1:0] q_ff, q_in;
   logic [CNT_BITS-1:0] s_ff, s_in, m_ff, m_in, i_ff, i_in, j_ff, j_in;
   logic [CNT_BITS:0] k_ff, k_in;
   logic [W-1:0] z_ff, z_in, c_ff, c_in, t_ff, t_in, r_ff, r_in;
   logic [W-1:0] zr_ff, zr_in;
   logic [W-1:0] b_ff, b_in, sq_ff, sq_in;
   logic [W-1:0] root_ff, root_in;
   logic flag_ff, flag_in;
   logic [W:0] rem_ff, rem_in;
   logic [W-1:0] ex_ff, ex_in, pb_ff, pb_in, pacc_ff, pacc_in;
   logic pw_start, pw_done;
   logic [W-1:0] pw_base, pw_exp;
   mul_req_type mreq;
   mul_rsp_type mrsp;
   logic [W:0] rem_sh;
   logic [W-1:0] half_p1;

   msr_mulmod u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign half_p1 = W'(({1'b0, p_ff} + 1'b1) >> 2);
   assign rem_sh  = {rem_ff[W-1:0], a_ff[W-1]};
   assign pw_done = (pw_ff == PW_DONE);

   // power unit next state
   always_comb begin
      pw_in = pw_ff;
      unique case (pw_ff)
         PW_IDLE:    if (pw_start) pw_in = (pw_exp == '0) ? PW_DONE : PW_MUL_ACC;
         PW_MUL_ACC: if (mrsp.done) pw_in = PW_MUL_SQ;
         PW_MUL_SQ:  if (mrsp.done) pw_in = (ex_ff[W-1:1] == '0) ? PW_DONE : PW_MUL_ACC;
         PW_DONE: begin
            if (pw_start) pw_in = (pw_exp == '0) ? PW_DONE : PW_MUL_ACC;
            else          pw_in = PW_IDLE;
         end
         default:    pw_in = PW_IDLE;
      endcase
   end

   logic mstart_ff, mstart_in;
   logic busy_ff, busy_in;
   logic [W-1:0] mx, my;
   logic ctl_mul;

   always_comb begin
      ex_in   = ex_ff;
      pb_in   = pb_ff;
      pacc_in = pacc_ff;
      unique case (pw_ff) inside
         PW_IDLE, PW_DONE: if (pw_start) begin
            ex_in   = pw_exp;
            pb_in   = (pw_base >= p_ff) ? pw_base - p_ff : pw_base;
            pacc_in = W'(1);
         end
         PW_MUL_ACC: if (mrsp.done && ex_ff[0]) pacc_in = mrsp.prod;
         PW_MUL_SQ: if (mrsp.done) begin
            pb_in = mrsp.prod;
            ex_in = ex_ff >> 1;
         end
         default: ;
      endcase
   end

   // multiplier issue: one start pulse after entering a multiply step
   always_comb begin
      mx = pacc_ff;
      my = pb_ff;
      ctl_mul = 1'b0;
      unique case (state_ff)
         ST_SQ:   begin mx = sq_ff; my = sq_ff; ctl_mul = 1'b1; end
         ST_B:    begin mx = b_ff;  my = b_ff;  ctl_mul = 1'b1; end
         ST_C:    begin mx = b_ff;  my = b_ff;  ctl_mul = 1'b1; end
         ST_T:    begin mx = t_ff;  my = c_ff;  ctl_mul = 1'b1; end
         ST_R:    begin mx = r_ff;  my = b_ff;  ctl_mul = 1'b1; end
         default: ;
      endcase
      if (pw_ff == PW_MUL_SQ) begin
         mx = pb_ff;
         my = pb_ff;
      end
      mstart_in = 1'b0;
      if ((pw_in == PW_MUL_ACC && pw_ff != PW_MUL_ACC) ||
          (pw_in == PW_MUL_SQ && pw_ff != PW_MUL_SQ))
         mstart_in = 1'b1;
      if (ctl_mul && !mstart_ff && !mrsp.done && busy_ff == 1'b0) mstart_in = 1'b1;
   end

   always_comb begin
      busy_in = busy_ff;
      if (mstart_ff) busy_in = 1'b1;
      if (mrsp.done) busy_in = 1'b0;
   end

   assign mreq.start = mstart_ff;
   assign mreq.x     = mx;
   assign mreq.y     = my;
   assign mreq.m     = p_ff;

   logic ctl_mdone;
   assign ctl_mdone = mrsp.done && ctl_mul;

   // controller next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (a_ff == '0 || p_ff == W'(2) || p_ff < W'(2) || !p_ff[0])
               state_in = ST_OUT;
            else
               state_in = ST_RED;
         end
         ST_RED: if (k_ff == (CNT_BITS+1)'(W - 1))
                    state_in = ST_EULER;
         ST_EULER:     state_in = ST_EULER_CHK;
         ST_EULER_CHK: begin
            if (rem_ff == '0) state_in = ST_OUT;
            else if (pw_done)
               state_in = (pacc_ff != W'(1)) ? ST_OUT : ST_FACTOR;
         end
         ST_FACTOR: if (q_ff[0]) state_in = (s_ff == CNT_BITS'(1)) ? ST_SHORT : ST_NR;
         ST_SHORT:  if (pw_done) state_in = ST_OUT;
         ST_NR:     state_in = ST_NR_CHK;
         ST_NR_CHK: if (pw_done) begin
            if (pacc_ff == p_ff - 1'b1) state_in = ST_POW_C;
            else if (z_ff == W'(NR_LAST)) state_in = ST_OUT;
            else state_in = ST_NR;
         end
         ST_POW_C: if (pw_done) state_in = ST_POW_T;
         ST_POW_T: if (pw_done) state_in = ST_POW_R;
         ST_POW_R: if (pw_done) state_in = ST_LOOP;
         ST_LOOP:  state_in = (t_ff == W'(1)) ? ST_OUT : ST_SQ_CHK;
         ST_SQ_CHK: begin
            if (sq_ff == W'(1) || i_ff >= m_ff)
               state_in = (i_ff >= m_ff) ? ST_OUT : ST_B_CHK;
            else state_in = ST_SQ;
         end
         ST_SQ:    if (ctl_mdone) state_in = ST_SQ_CHK;
         ST_B_CHK: state_in = (j_ff + 1'b1 < m_ff - i_ff) ? ST_B : ST_C;
         ST_B:     if (ctl_mdone) state_in = ST_B_CHK;
         ST_C:     if (ctl_mdone) state_in = ST_T;
         ST_T:     if (ctl_mdone) state_in = ST_R;
         ST_R:     if (ctl_mdone) state_in = ST_LOOP;
         ST_OUT:   if (rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // controller datapath and power requests
   always_comb begin
      a_in = a_ff; p_in = p_ff; q_in = q_ff; s_in = s_ff; m_in = m_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; z_in = z_ff; c_in = c_ff;
      t_in = t_ff; r_in = r_ff; b_in = b_ff; sq_in = sq_ff; zr_in = zr_ff;
      root_in = root_ff; flag_in = flag_ff; rem_in = rem_ff;
      pw_start = 1'b0; pw_base = rem_ff[W-1:0]; pw_exp = (p_ff - 1'b1) >> 1;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            a_in = req_tdata[W-1:0];
            p_in = req_tdata[32+W-1:32];
            root_in = '0; flag_in = 1'b0; rem_in = '0; k_in = '0;
         end
         ST_CHECK: begin
            if (a_ff == '0) ;
            else if (p_ff == W'(2)) root_in = W'(a_ff[0]);
            else if (p_ff < W'(2) || !p_ff[0]) flag_in = 1'b1;
         end
         ST_RED: begin
            // restoring division, one quotient bit a cycle
            rem_in = (rem_sh >= {1'b0, p_ff}) ? rem_sh - {1'b0, p_ff} : rem_sh;
            a_in = {a_ff[W-2:0], 1'b0};
            k_in = k_ff + 1'b1;
         end
         ST_EULER: begin
            if (rem_ff != '0) pw_start = 1'b1;
            q_in = p_ff - 1'b1; s_in = '0;
         end
         ST_EULER_CHK: if (rem_ff != '0 && pw_done && pacc_ff != W'(1)) flag_in = 1'b1;
         ST_FACTOR: if (!q_ff[0]) begin
            q_in = q_ff >> 1; s_in = s_ff + 1'b1;
         end else if (s_ff == CNT_BITS'(1)) begin
            pw_start = 1'b1; pw_exp = half_p1;
         end else begin
            z_in = W'(2); zr_in = W'(2);
         end
         ST_SHORT: if (pw_done) root_in = pacc_ff;
         ST_NR: begin pw_start = 1'b1; pw_base = zr_ff; end
         ST_NR_CHK: if (pw_done) begin
            if (pacc_ff == p_ff - 1'b1) begin
               pw_start = 1'b1; pw_base = zr_ff; pw_exp = q_ff; m_in = s_ff;
            end else if (z_ff == W'(NR_LAST)) flag_in = 1'b1;
            else begin
               z_in  = z_ff + 1'b1;
               zr_in = (zr_ff + 1'b1 == p_ff) ? '0 : zr_ff + 1'b1;
            end
         end
         ST_POW_C: if (pw_done) begin
            c_in = pacc_ff; pw_start = 1'b1; pw_exp = q_ff;
         end
         ST_POW_T: if (pw_done) begin
            t_in = pacc_ff; pw_start = 1'b1; pw_exp = (q_ff >> 1) + 1'b1;
         end
         ST_POW_R: if (pw_done) r_in = pacc_ff;
         ST_LOOP: begin
            if (t_ff == W'(1)) root_in = r_ff;
            sq_in = t_ff; i_in = '0;
         end
         ST_SQ_CHK: begin
            if (i_ff >= m_ff && sq_ff != W'(1)) flag_in = 1'b1;
            else if (sq_ff == W'(1) && i_ff >= m_ff) flag_in = 1'b1;
            b_in = c_ff; j_in = '0;
         end
         ST_SQ: if (ctl_mdone) begin sq_in = mrsp.prod; i_in = i_ff + 1'b1; end
         ST_B:  if (ctl_mdone) begin b_in = mrsp.prod; j_in = j_ff + 1'b1; end
         ST_C:  if (ctl_mdone) begin c_in = mrsp.prod; m_in = i_ff; end
         ST_T:  if (ctl_mdone) t_in = mrsp.prod;
         ST_R:  if (ctl_mdone) r_in = mrsp.prod;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pw_ff     <= PW_IDLE;
         mstart_ff <= 1'b0;
         busy_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pw_ff     <= pw_in;
         mstart_ff <= mstart_in;
         busy_ff   <= busy_in;
      end
      a_ff <= a_in; p_ff <= p_in; q_ff <= q_in; s_ff <= s_in; m_ff <= m_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; z_ff <= z_in; c_ff <= c_in;
      t_ff <= t_in; r_ff <= r_in; b_ff <= b_in; sq_ff <= sq_in; zr_ff <= zr_in;
      root_ff <= root_in; flag_ff <= flag_in; rem_ff <= rem_in;
      ex_ff <= ex_in; pb_ff <= pb_in; pacc_ff <= pacc_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {7'b0, flag_ff, root_ff};

`ifndef SYNTH
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && flag_ff) |-> (root_ff == '0)) else $error("flag with root");
`endif

endmodule
